// ----- rtl/pcsp_pkg.sv -----
// ----------------------------------------------------------------------------
// pcsp_pkg: shared types and constants of the port command stream parser
// Command codes, parse phases, result kinds and the argument count table.
// ----------------------------------------------------------------------------
package pcsp_pkg;

    localparam int BYTE_W = 8;
    localparam int CODE_W = 5;
    localparam int ARG_N  = 3;

    // commands with a special role
    localparam logic [CODE_W-1:0] CMD_LOOPBACK  = 5'd2;
    localparam logic [CODE_W-1:0] CMD_TX        = 5'd16;
    localparam logic [CODE_W-1:0] CMD_XFER      = 5'd18;
    localparam logic [CODE_W-1:0] CMD_SPI_ON    = 5'd10;
    localparam logic [CODE_W-1:0] CMD_PWM_CYCLE = 5'd28;
    localparam logic [CODE_W-1:0] CMD_DAC_WRITE = 5'd25;

    typedef enum logic [1:0] {
        PH_CMD = 2'd0,
        PH_ARG = 2'd1,
        PH_PAY = 2'd2,
        PH_ERR = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        KIND_CMD     = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_ERROR   = 2'd2
    } t_item_kind;

    typedef struct packed {
        logic       known;
        logic [1:0] count;
    } t_arg_info;

    // argument count per command byte; codes above 31 are unknown
    function automatic t_arg_info arg_lookup(input logic [BYTE_W-1:0] b);
        t_arg_info info;
        info.known = 1'b1;
        info.count = 2'd1;
        if (b[7:5] != 3'd0) begin
            info.known = 1'b0;
            info.count = 2'd0;
        end else begin
            unique case (b[4:0])
                5'd0, 5'd1, 5'd11, 5'd13, 5'd15, 5'd20:
                    info.count = 2'd0;
                5'd14, CMD_DAC_WRITE:
                    info.count = 2'd2;
                CMD_SPI_ON, 5'd27, CMD_PWM_CYCLE:
                    info.count = 2'd3;
                5'd9, 5'd29, 5'd30, 5'd31: begin
                    info.known = 1'b0;
                    info.count = 2'd0;
                end
                default:
                    info.count = 2'd1;
            endcase
        end
        return info;
    endfunction

    function automatic logic has_payload(input logic [CODE_W-1:0] code);
        return (code == CMD_LOOPBACK) || (code == CMD_TX) || (code == CMD_XFER);
    endfunction

endpackage

// ----- rtl/pcsp_in_if.sv -----
// ----------------------------------------------------------------------------
// pcsp_in_if: command byte channel
// Valid/ready channel that carries one host stream byte per request.
// ----------------------------------------------------------------------------
interface pcsp_in_if;

    logic                          valid;
    logic                          ready;
    logic [pcsp_pkg::BYTE_W-1:0]   stream_byte;

    modport source (output valid, output stream_byte, input ready);
    modport sink   (input valid, input stream_byte, output ready);

endinterface

// ----- rtl/pcsp_out_if.sv -----
// ----------------------------------------------------------------------------
// pcsp_out_if: decoded item channel
// Valid/ready channel that carries one decoded command, payload or error.
// ----------------------------------------------------------------------------
interface pcsp_out_if;

    logic                          valid;
    logic                          ready;
    pcsp_pkg::t_item_kind          item_kind;
    logic [pcsp_pkg::CODE_W-1:0]   command_code;
    logic [pcsp_pkg::BYTE_W-1:0]   first_arg;
    logic [pcsp_pkg::BYTE_W-1:0]   second_arg;
    logic [pcsp_pkg::BYTE_W-1:0]   third_arg;
    logic [pcsp_pkg::BYTE_W-1:0]   payload_data;
    logic                          payload_last;

    modport source (
        output valid, output item_kind, output command_code,
        output first_arg, output second_arg, output third_arg,
        output payload_data, output payload_last,
        input  ready
    );
    modport sink (
        input  valid, input item_kind, input command_code,
        input  first_arg, input second_arg, input third_arg,
        input  payload_data, input payload_last,
        output ready
    );

endinterface

// ----- rtl/port_command_stream_parser_top.sv -----
// ----------------------------------------------------------------------------
// port_command_stream_parser_top: host command stream parser
// Decodes command bytes, collects arguments and passes payload bytes through.
// ----------------------------------------------------------------------------
// A result is registered: it is valid in the cycle after the byte that causes it is accepted.
// Throughput: one byte per cycle while the sink takes results; the phase/counter update and table lookup
// sit between the state registers and the single result register.
// Ready drops only while the result register holds an item the sink stalls.
// Reset (i_rst_n low, synchronous) returns to the command phase and clears
// the sticky error, the stored arguments and the result valid flag.
module port_command_stream_parser_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    pcsp_in_if.sink           i_in,
    pcsp_out_if.source        o_out
);

    // parse state
    pcsp_pkg::t_phase                r_phase, n_phase;
    logic [pcsp_pkg::CODE_W-1:0]     r_cmd, n_cmd;
    logic [1:0]                      r_args_left, n_args_left;
    logic [1:0]                      r_arg_pos, n_arg_pos;
    logic [pcsp_pkg::BYTE_W-1:0]     r_arg [pcsp_pkg::ARG_N];
    logic [pcsp_pkg::BYTE_W-1:0]     n_arg [pcsp_pkg::ARG_N];
    logic [pcsp_pkg::BYTE_W-1:0]     r_pay_left, n_pay_left;

    // result register
    logic                            r_out_valid, n_out_valid;
    pcsp_pkg::t_item_kind            r_out_kind, n_out_kind;
    logic [pcsp_pkg::CODE_W-1:0]     r_out_cmd, n_out_cmd;
    logic [pcsp_pkg::BYTE_W-1:0]     r_out_arg [pcsp_pkg::ARG_N];
    logic [pcsp_pkg::BYTE_W-1:0]     n_out_arg [pcsp_pkg::ARG_N];
    logic [pcsp_pkg::BYTE_W-1:0]     r_out_data, n_out_data;
    logic                            r_out_last, n_out_last;

    logic                            w_in_ready;
    logic                            w_accept;
    logic [pcsp_pkg::BYTE_W-1:0]     w_byte;
    pcsp_pkg::t_arg_info             w_info;

    // handshake: take a byte whenever the result slot is free or draining
    assign w_in_ready = !r_out_valid || o_out.ready;
    assign w_accept   = i_in.valid && w_in_ready;
    assign w_byte     = i_in.stream_byte;
    assign w_info     = pcsp_pkg::arg_lookup(w_byte);
    assign i_in.ready = w_in_ready;

    // next state and result
    always_comb begin
        n_phase     = r_phase;
        n_cmd       = r_cmd;
        n_args_left = r_args_left;
        n_arg_pos   = r_arg_pos;
        n_arg       = r_arg;
        n_pay_left  = r_pay_left;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_kind  = r_out_kind;
        n_out_cmd   = r_out_cmd;
        n_out_arg   = r_out_arg;
        n_out_data  = r_out_data;
        n_out_last  = r_out_last;

        if (w_accept) begin
            n_out_kind = pcsp_pkg::KIND_CMD;
            n_out_data = '0;
            n_out_last = 1'b0;
            unique case (r_phase)
                pcsp_pkg::PH_CMD: begin
                    n_arg       = '{default: '0};
                    n_arg_pos   = 2'd0;
                    n_cmd       = w_byte[pcsp_pkg::CODE_W-1:0];
                    n_args_left = w_info.count;
                    n_pay_left  = '0;
                    if (!w_info.known) begin
                        n_phase     = pcsp_pkg::PH_ERR;
                        n_out_valid = 1'b1;
                        n_out_kind  = pcsp_pkg::KIND_ERROR;
                    end else if (w_info.count == 2'd0) begin
                        // no arguments: decoded at once, no payload length
                        n_phase     = pcsp_pkg::PH_CMD;
                        n_out_valid = 1'b1;
                    end else begin
                        n_phase = pcsp_pkg::PH_ARG;
                    end
                end
                pcsp_pkg::PH_ARG: begin
                    for (int i = 0; i < pcsp_pkg::ARG_N; i++) begin
                        if (r_arg_pos == i[1:0]) begin
                            n_arg[i] = w_byte;
                        end
                    end
                    n_arg_pos   = r_arg_pos + 2'd1;
                    n_args_left = (r_args_left != 2'd0) ? r_args_left - 2'd1 : 2'd0;
                    if (n_args_left == 2'd0 || r_arg_pos == 2'd2) begin
                        n_args_left = 2'd0;
                        n_out_valid = 1'b1;
                        if (pcsp_pkg::has_payload(r_cmd) && n_arg[0] != '0) begin
                            n_pay_left = n_arg[0];
                            n_phase    = pcsp_pkg::PH_PAY;
                        end else begin
                            n_pay_left = '0;
                            n_phase    = pcsp_pkg::PH_CMD;
                        end
                    end
                end
                pcsp_pkg::PH_PAY: begin
                    n_pay_left  = (r_pay_left != '0) ? r_pay_left - 8'd1 : '0;
                    n_out_valid = 1'b1;
                    n_out_kind  = pcsp_pkg::KIND_PAYLOAD;
                    n_out_data  = w_byte;
                    n_out_last  = (n_pay_left == '0);
                    if (n_pay_left == '0) begin
                        n_phase = pcsp_pkg::PH_CMD;
                    end
                end
                pcsp_pkg::PH_ERR: begin
                    // sticky: bytes are swallowed until reset
                    n_out_valid = 1'b0;
                end
                default: begin
                    n_phase = pcsp_pkg::PH_ERR;
                end
            endcase
            n_out_cmd = n_cmd;
            n_out_arg = n_arg;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= pcsp_pkg::PH_CMD;
            r_cmd       <= '0;
            r_args_left <= 2'd0;
            r_arg_pos   <= 2'd0;
            r_arg       <= '{default: '0};
            r_pay_left  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_cmd       <= n_cmd;
            r_args_left <= n_args_left;
            r_arg_pos   <= n_arg_pos;
            r_arg       <= n_arg;
            r_pay_left  <= n_pay_left;
            r_out_valid <= n_out_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        r_out_kind <= n_out_kind;
        r_out_cmd  <= n_out_cmd;
        r_out_arg  <= n_out_arg;
        r_out_data <= n_out_data;
        r_out_last <= n_out_last;
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.item_kind    = r_out_kind;
    assign o_out.command_code = r_out_cmd;
    assign o_out.first_arg    = r_out_arg[0];
    assign o_out.second_arg   = r_out_arg[1];
    assign o_out.third_arg    = r_out_arg[2];
    assign o_out.payload_data = r_out_data;
    assign o_out.payload_last = r_out_last;

    // checks
    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == pcsp_pkg::PH_ERR |=> r_phase == pcsp_pkg::PH_ERR)
        else $error("error phase left without reset");

    a_pay_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == pcsp_pkg::PH_PAY |-> r_pay_left != '0)
        else $error("payload phase with zero bytes remaining");

    a_arg_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == pcsp_pkg::PH_ARG |-> r_args_left != 2'd0 && r_arg_pos != 2'd3)
        else $error("argument phase with nothing to collect");

    a_pay_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && r_phase == pcsp_pkg::PH_PAY |=>
            r_out_valid && r_out_kind == pcsp_pkg::KIND_PAYLOAD)
        else $error("payload byte did not produce a payload item");

    a_unknown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && r_phase == pcsp_pkg::PH_CMD && !w_info.known |=>
            r_phase == pcsp_pkg::PH_ERR && r_out_valid &&
            r_out_kind == pcsp_pkg::KIND_ERROR)
        else $error("unknown command not flagged");

endmodule

// ----- dv/port_command_stream_parser_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// port_command_stream_parser_top_tb: self-checking bench for the stream parser
// Sends command, argument and payload bytes over the input channel and runs a
// cycle-free decode model of the parser next to the block. Every result
// request is checked field by field against the oldest predicted item. Random
// stalls on both channels while idling is on; the sticky error is exercised last, since only
// reset clears it.
// ----------------------------------------------------------------------------
module port_command_stream_parser_top_tb;

    typedef struct {
        pcsp_pkg::t_item_kind                kind;
        logic [pcsp_pkg::CODE_W-1:0]         code;
        logic [pcsp_pkg::BYTE_W-1:0]         args [pcsp_pkg::ARG_N];
        logic [pcsp_pkg::BYTE_W-1:0]         data;
        logic                                last;
    } t_decoded_item;

    // argument bytes per command code; undefined codes are flagged separately
    localparam logic [1:0] ARG_COUNT [32] = '{
        2'd0, 2'd0, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1,
        2'd1, 2'd0, 2'd3, 2'd0, 2'd1, 2'd0, 2'd2, 2'd0,
        2'd1, 2'd1, 2'd1, 2'd1, 2'd0, 2'd1, 2'd1, 2'd1,
        2'd1, 2'd2, 2'd1, 2'd3, 2'd3, 2'd0, 2'd0, 2'd0
    };
    localparam logic [31:0] UNDEFINED_CODES = 32'hE000_0200;
    localparam logic [pcsp_pkg::CODE_W-1:0] CMD_RX = 5'd17;

    logic i_clk;
    logic i_rst_n;

    pcsp_in_if  in_if ();
    pcsp_out_if out_if ();

    port_command_stream_parser_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // decode model state
    pcsp_pkg::t_phase                dec_phase;
    logic [pcsp_pkg::CODE_W-1:0]     dec_cmd;
    logic [1:0]                      dec_args_left;
    int                              dec_arg_idx;
    logic [pcsp_pkg::BYTE_W-1:0]     dec_args [pcsp_pkg::ARG_N];
    logic [pcsp_pkg::BYTE_W-1:0]     dec_payload_left;

    t_decoded_item      pending_items [$];
    int                 error_count;
    int                 bytes_sent;
    bit                 idle_on;

    always #2 i_clk = ~i_clk;

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        error_count++;
    endtask

    function automatic void queue_item(input pcsp_pkg::t_item_kind kind,
                                       input logic [7:0] data, input logic last);
        t_decoded_item it;
        it.kind = kind;
        it.code = dec_cmd;
        it.args = dec_args;
        it.data = data;
        it.last = last;
        pending_items.push_back(it);
    endfunction

    // all arguments in: decoded command, then payload or back to command phase
    function automatic void close_command();
        queue_item(pcsp_pkg::KIND_CMD, 8'h00, 1'b0);
        if ((dec_cmd == pcsp_pkg::CMD_LOOPBACK || dec_cmd == pcsp_pkg::CMD_TX ||
                dec_cmd == pcsp_pkg::CMD_XFER) && dec_args[0] != 8'h00) begin
            dec_payload_left = dec_args[0];
            dec_phase        = pcsp_pkg::PH_PAY;
        end else begin
            dec_payload_left = 8'h00;
            dec_phase        = pcsp_pkg::PH_CMD;
        end
    endfunction

    // advance the decode model by one accepted stream byte
    function automatic void decode_byte(input logic [pcsp_pkg::BYTE_W-1:0] b);
        case (dec_phase)
            pcsp_pkg::PH_CMD: begin
                dec_args    = '{default: 8'h00};
                dec_arg_idx = 0;
                dec_cmd     = b[4:0];
                if (b[7:5] != 3'd0 || UNDEFINED_CODES[b[4:0]]) begin
                    dec_phase        = pcsp_pkg::PH_ERR;
                    dec_args_left    = 2'd0;
                    dec_payload_left = 8'h00;
                    queue_item(pcsp_pkg::KIND_ERROR, 8'h00, 1'b0);
                end else begin
                    dec_args_left = ARG_COUNT[b[4:0]];
                    if (dec_args_left == 2'd0)
                        close_command();
                    else
                        dec_phase = pcsp_pkg::PH_ARG;
                end
            end
            pcsp_pkg::PH_ARG: begin
                if (dec_arg_idx < pcsp_pkg::ARG_N)
                    dec_args[dec_arg_idx] = b;
                dec_arg_idx++;
                dec_args_left = dec_args_left - 2'd1;
                if (dec_args_left == 2'd0 || dec_arg_idx >= pcsp_pkg::ARG_N) begin
                    dec_args_left = 2'd0;
                    close_command();
                end
            end
            pcsp_pkg::PH_PAY: begin
                dec_payload_left = dec_payload_left - 8'd1;
                queue_item(pcsp_pkg::KIND_PAYLOAD, b, dec_payload_left == 8'h00);
                if (dec_payload_left == 8'h00)
                    dec_phase = pcsp_pkg::PH_CMD;
            end
            default: ;
        endcase
    endfunction

    // one request on the input channel, with an optional gap before it
    task automatic send_byte(input logic [pcsp_pkg::BYTE_W-1:0] b);
        int gap;
        gap = (idle_on && $urandom_range(0, 4) == 0) ? $urandom_range(1, 9) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_if.valid       <= 1'b1;
        in_if.stream_byte <= b;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        decode_byte(b);
        bytes_sent++;
    endtask

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // full well-formed command: code, arguments and payload
    task automatic send_random_command();
        logic [pcsp_pkg::CODE_W-1:0] code;
        logic [7:0]                  len;
        int                          pick;
        if ($urandom_range(0, 9) < 3) begin
            pick = $urandom_range(0, 2);
            code = (pick == 0) ? pcsp_pkg::CMD_LOOPBACK :
                   (pick == 1) ? pcsp_pkg::CMD_TX : pcsp_pkg::CMD_XFER;
        end else begin
            do code = 5'($urandom_range(0, 28)); while (UNDEFINED_CODES[code]);
        end
        send_byte({3'd0, code});
        if (code == pcsp_pkg::CMD_LOOPBACK || code == pcsp_pkg::CMD_TX ||
                code == pcsp_pkg::CMD_XFER) begin
            pick = $urandom_range(0, 99);
            if (pick < 6)
                len = 8'h00;
            else if (pick < 8)
                len = 8'($urandom_range(100, 255));
            else
                len = 8'($urandom_range(1, 8));
            send_byte(len);
            repeat (len) send_byte(rand_byte());
        end else begin
            repeat (ARG_COUNT[code]) send_byte(rand_byte());
        end
    endtask

    // commands without payload, covering every argument count, argument extremes
    task automatic test_argument_counts();
        send_byte(8'd0);
        send_byte(8'd20);
        send_byte(8'd3);  send_byte(8'h00);
        send_byte(8'd8);  send_byte(8'hFF);
        send_byte(8'd14); send_byte(8'hFF); send_byte(8'h00);
        send_byte({3'd0, pcsp_pkg::CMD_PWM_CYCLE});
        send_byte(8'h00); send_byte(8'hFF); send_byte(8'h5A);
    endtask

    // zero-length echo, single-byte and multi-byte payloads, receive-only length
    task automatic test_payload_commands();
        send_byte({3'd0, pcsp_pkg::CMD_LOOPBACK}); send_byte(8'h00);
        send_byte({3'd0, pcsp_pkg::CMD_TX});   send_byte(8'h01); send_byte(8'hA5);
        send_byte({3'd0, pcsp_pkg::CMD_XFER}); send_byte(8'h02);
        send_byte(8'h00); send_byte(8'hFF);
        send_byte({3'd0, CMD_RX});             send_byte(8'h07);
    endtask

    task automatic test_random_traffic(input int byte_target);
        while (bytes_sent < byte_target) send_random_command();
    endtask

    // random command, then an unknown command byte, then bytes that the error phase must swallow
    task automatic test_sticky_error();
        logic [7:0] bad;
        case ($urandom_range(0, 2))
            0:       bad = 8'd9;
            1:       bad = 8'($urandom_range(29, 31));
            default: bad = 8'($urandom_range(32, 255));
        endcase
        send_random_command();
        send_byte(bad);
        send_byte({3'd0, pcsp_pkg::CMD_LOOPBACK});
        send_byte(8'h03);
        repeat (6) send_byte(rand_byte());
        send_byte(8'd0);
    endtask

    // sink side: random stall bursts while idling is on
    always begin
        @(negedge i_clk);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            out_if.ready <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge i_clk);
        end
        out_if.ready <= 1'b1;
    end

    // result checker
    always @(posedge i_clk) begin : check_results
        t_decoded_item exp_item;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_items.size() == 0) begin
                report_mismatch($sformatf("unexpected result kind %0d code %0d",
                                          out_if.item_kind, out_if.command_code));
            end else begin
                exp_item = pending_items.pop_front();
                if (out_if.item_kind !== exp_item.kind)
                    report_mismatch($sformatf("item_kind %0d, want %0d",
                                              out_if.item_kind, exp_item.kind));
                if (out_if.command_code !== exp_item.code)
                    report_mismatch($sformatf("command_code %0d, want %0d",
                                              out_if.command_code, exp_item.code));
                if (out_if.first_arg !== exp_item.args[0])
                    report_mismatch($sformatf("first_arg %h, want %h",
                                              out_if.first_arg, exp_item.args[0]));
                if (out_if.second_arg !== exp_item.args[1])
                    report_mismatch($sformatf("second_arg %h, want %h",
                                              out_if.second_arg, exp_item.args[1]));
                if (out_if.third_arg !== exp_item.args[2])
                    report_mismatch($sformatf("third_arg %h, want %h",
                                              out_if.third_arg, exp_item.args[2]));
                if (out_if.payload_data !== exp_item.data)
                    report_mismatch($sformatf("payload_data %h, want %h",
                                              out_if.payload_data, exp_item.data));
                if (out_if.payload_last !== exp_item.last)
                    report_mismatch($sformatf("payload_last %b, want %b",
                                              out_if.payload_last, exp_item.last));
            end
        end
    end

    // run limit
    initial begin
        #2_000_000;
        $display("port_command_stream_parser_top_tb: done, errors");
        $finish;
    end

    // test sequence
    initial begin
        i_clk             = 1'b0;
        i_rst_n           = 1'b0;
        in_if.valid       = 1'b0;
        in_if.stream_byte = 8'h00;
        out_if.ready      = 1'b0;
        idle_on           = 1'b1;
        error_count       = 0;
        bytes_sent        = 0;
        dec_phase         = pcsp_pkg::PH_CMD;
        dec_cmd           = 5'd0;
        dec_args_left     = 2'd0;
        dec_arg_idx       = 0;
        dec_args          = '{default: 8'h00};
        dec_payload_left  = 8'h00;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_argument_counts();
        test_payload_commands();
        test_random_traffic(1000);
        idle_on = 1'b0;
        test_random_traffic(1140);
        test_sticky_error();

        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (pending_items.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (error_count == 0)
            $display("port_command_stream_parser_top_tb: done, clean");
        else
            $display("port_command_stream_parser_top_tb: done, errors");
        $finish;
    end

endmodule

// ----- port_command_stream_parser_top.f -----
rtl/pcsp_pkg.sv
rtl/pcsp_in_if.sv
rtl/pcsp_out_if.sv
rtl/port_command_stream_parser_top.sv
dv/port_command_stream_parser_top_tb.sv
